// ----- rtl/bcir_pkg.sv -----
package bcir_pkg;

    // Pixel values on the output channel
    localparam logic [7:0] PIX_WHITE = 8'd255;
    localparam logic [7:0] PIX_BLACK = 8'd0;

    // Dimension limits and register defaults
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int MIN_DIM        = 3;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 11'd256;
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 11'd256;
    localparam logic [7:0]            RST_THRESHOLD    = 8'd128;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    typedef struct packed {
        logic [7:0] gray;
        logic       drain;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_end;
    } pix_out_t;

    // One column of the 3x3 window: bit 0 top row, bit 2 bottom row; 1 = black
    typedef logic [2:0] win_col_t;

endpackage

// ----- rtl/bcir_cell.sv -----
module bcir_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  bcir_pkg::win_col_t col_in,
    output bcir_pkg::win_col_t col_out
);
    import bcir_pkg::*;

    win_col_t col_reg;
    win_col_t col_next;

    always_comb
    begin
        col_next = shift ? col_in : col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

// ----- rtl/bcir_line_mem.sv -----
module bcir_line_mem #(
    parameter int DEPTH = bcir_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [1:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [1:0]    rdata
);
    import bcir_pkg::*;

    // bit 0: row above the middle line, bit 1: middle line
    logic [1:0] mem [DEPTH];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/binary_contour_interior_removal.sv -----
// Binary contour extraction on a gray pixel stream (3x3 interior removal).
// pixel channel: one gray pixel per transfer in raster order, plus drain items;
// after each frame the feeder sends image_width+1 drain items.
// contour channel: one contour pixel per transfer (0 black, 255 white), with
// frame_end set on the last pixel of the frame.
// cfg port: cfg_we/cfg_index/cfg_data, write only while the block is idle.
// Throughput: one pixel per clock while not stalled, set by the single-port-per-side
// line memory (one read and one write each cycle) and the two-cell window chain.
// Position: an output pixel lies image_width+1 items behind the input in the
// raster; the item that completes its window is held in the window stage
// register before the result is written to the output register.
// Reset: control and configuration registers take their defaults; then a
// clearing pass zeroes all MAX_WIDTH line memory entries, with pixel_stall high.
// A stalled output holds its data; one more item is taken into the window
// stage, then pixel_stall rises until the output register drains.
module binary_contour_interior_removal #(
    parameter int MAX_WIDTH  = bcir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bcir_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 pixel_valid,
    output logic                                 pixel_stall,
    input  bcir_pkg::pix_in_t                    pixel_data,
    output logic                                 contour_valid,
    input  logic                                 contour_stall,
    output bcir_pkg::pix_out_t                   contour_data,
    input  logic                                 cfg_we,
    input  logic [bcir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bcir_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bcir_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int RAW = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int DWW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int DHW = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
    localparam logic [1:0] ROW_FULL = 2'd2;

    // configuration
    logic [CFG_DATA_W-1:0] image_width_reg, image_height_reg;
    logic [7:0]            threshold_reg;
    logic [WW-1:0]         w;
    logic [HW-1:0]         h;
    logic [DWW-1:0]        width_ext;
    logic [DHW-1:0]        height_ext;

    // clearing pass
    logic          clear_active_reg, clear_active_next;
    logic [AW-1:0] clear_addr_reg, clear_addr_next;

    // window stage
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_black_reg;
    logic          s1_fire;
    logic          accept;
    logic [1:0]    line_rdata;

    // positions
    logic [AW-1:0]  in_col_reg, in_col_next;
    logic [1:0]     in_row_reg, in_row_next;
    logic [AW-1:0]  out_col_reg, out_col_next;
    logic [RAW-1:0] out_row_reg, out_row_next;

    // output register
    logic     out_valid_reg, out_valid_next;
    pix_out_t out_data_reg, out_data_next;
    logic     out_ready;

    // window chain
    win_col_t   new_col, col2, col1;
    logic [8:0] window_next;
    logic       emit, interior, in_wrap, out_wrap, last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            threshold_reg    <= RST_THRESHOLD;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_THRESHOLD:    threshold_reg    <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        width_ext  = DWW'(image_width_reg);
        height_ext = DHW'(image_height_reg);
        if (width_ext < DWW'(MIN_DIM))
            w = WW'(MIN_DIM);
        else if (width_ext > DWW'(MAX_WIDTH))
            w = WW'(MAX_WIDTH);
        else
            w = WW'(width_ext);
        if (height_ext < DHW'(MIN_DIM))
            h = HW'(MIN_DIM);
        else if (height_ext > DHW'(MAX_HEIGHT))
            h = HW'(MAX_HEIGHT);
        else
            h = HW'(height_ext);
    end

    // handshake
    assign out_ready   = !out_valid_reg || !contour_stall;
    assign emit        = (in_row_reg == ROW_FULL) || (in_row_reg == 2'd1 && in_col_reg != '0);
    assign s1_fire     = s1_valid_reg && (out_ready || !emit);
    assign pixel_stall = clear_active_reg || (s1_valid_reg && !s1_fire);
    assign accept      = pixel_valid && !pixel_stall;

    // window: newest column enters cell 2, the older stored column sits in cell 1
    assign new_col     = {s1_black_reg, line_rdata[1], line_rdata[0]};
    assign window_next = {new_col, col2, col1};

    bcir_cell u_cell2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s1_fire),
        .col_in  (new_col),
        .col_out (col2)
    );

    bcir_cell u_cell1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (s1_fire),
        .col_in  (col2),
        .col_out (col1)
    );

    // positions and result
    always_comb
    begin
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        in_wrap  = (WW'(in_col_reg) + WW'(1)) >= w;
        out_wrap = (WW'(out_col_reg) + WW'(1)) >= w;
        last_row = (HW'(out_row_reg) + HW'(1)) >= h;
        interior = (out_row_reg != '0) && ((HW'(out_row_reg) + HW'(1)) < h)
                && (out_col_reg != '0) && ((WW'(out_col_reg) + WW'(1)) < w);

        if (out_ready)
            out_valid_next = 1'b0;

        if (s1_fire)
        begin
            if (in_wrap)
            begin
                in_col_next = '0;
                if (in_row_reg != ROW_FULL)
                    in_row_next = in_row_reg + 2'd1;
            end
            else
            begin
                in_col_next = in_col_reg + AW'(1);
            end

            if (emit)
            begin
                out_valid_next          = 1'b1;
                out_data_next.pixel_out = PIX_WHITE;
                out_data_next.frame_end = 1'b0;
                if (interior && window_next[4] && window_next != 9'h1FF)
                    out_data_next.pixel_out = PIX_BLACK;

                if (out_wrap)
                begin
                    out_col_next = '0;
                    if (last_row)
                    begin
                        out_data_next.frame_end = 1'b1;
                        out_row_next = '0;
                        in_row_next  = '0;
                        in_col_next  = '0;
                    end
                    else
                    begin
                        out_row_next = out_row_reg + RAW'(1);
                    end
                end
                else
                begin
                    out_col_next = out_col_reg + AW'(1);
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_fire)
            s1_valid_next = 1'b0;
        if (accept)
            s1_valid_next = 1'b1;

        clear_active_next = clear_active_reg;
        clear_addr_next   = clear_addr_reg;
        if (clear_active_reg)
        begin
            clear_addr_next = clear_addr_reg + AW'(1);
            if (clear_addr_reg == AW'(MAX_WIDTH - 1))
                clear_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
            s1_valid_reg     <= 1'b0;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            clear_active_reg <= clear_active_next;
            clear_addr_reg   <= clear_addr_next;
            s1_valid_reg     <= s1_valid_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
            s1_black_reg <= !pixel_data.drain && (pixel_data.gray < threshold_reg);
    end

    // Read for the next item goes to the column after any update this cycle.
    // Only at frame end can it hit the column being written (column 0); the
    // old value read then only reaches windows of first-row border pixels.
    bcir_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_mem (
        .clk   (clk),
        .we    (clear_active_reg || s1_fire),
        .waddr (clear_active_reg ? clear_addr_reg : in_col_reg),
        .wdata (clear_active_reg ? 2'b00 : {s1_black_reg, line_rdata[1]}),
        .re    (accept),
        .raddr (in_col_next),
        .rdata (line_rdata)
    );

    assign contour_valid = out_valid_reg;
    assign contour_data  = out_data_reg;

endmodule
